// ===== rtl/core/ids_pkg.sv =====
// ----------------------------------------------------------------------------
// ids_pkg
// shared types and constants of the dominator set engine
// ----------------------------------------------------------------------------
package ids_pkg;

  localparam int unsigned MAX_NODES_DEF = 64;
  localparam int unsigned NODE_W        = 7;
  localparam int unsigned ROW_W         = 64;

  localparam logic [1:0] MODE_ADD     = 2'd0;
  localparam logic [1:0] MODE_COMPUTE = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_ROW = 2'd2;

endpackage

// ===== rtl/core/ids_if.sv =====
// ----------------------------------------------------------------------------
// ids_in_if / ids_out_if
// valid/ready channels for command words and result words
// ----------------------------------------------------------------------------
interface ids_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [6:0] from_node;
  logic [6:0] to_node;
  modport source (output valid, mode, from_node, to_node, input ready);
  modport sink   (input valid, mode, from_node, to_node, output ready);
endinterface

interface ids_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [6:0]  node;
  logic [63:0] dominators;
  logic        last;
  modport source (output valid, status, node, dominators, last, input ready);
  modport sink   (input valid, status, node, dominators, last, output ready);
endinterface

// ===== rtl/core/ids_mem.sv =====
// ----------------------------------------------------------------------------
// ids_mem
// single write, single read synchronous row memory
// ----------------------------------------------------------------------------
module ids_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/iterative_dominator_sets.sv =====
// ----------------------------------------------------------------------------
// iterative_dominator_sets
// predecessor matrix and dominator rows in memories, swept by a sequencer
// ----------------------------------------------------------------------------
// channel  dir  fields
// in       in   mode, from_node, to_node
// out      out  status, node, dominators, last
// cfg      in   node_count (write only)
// after reset: predecessor memory cleared row by row, ready low
// add edge: EDGE_RD, EDGE_WR, OUT into the output register; rejected edge / mode 3:
//   EDGE_RD, OUT; clear: one predecessor row per cycle, every row, then OUT
// compute: INIT per node, then per sweep and node but the first: NODE_RD, NODE_PR,
//   SCAN and ACC per predecessor (one dominator memory read each), SCAN, WB; then
//   EMIT_RD, EMIT per emitted row; one item at a time; out stalls hold the sequencer
// ----------------------------------------------------------------------------
module iterative_dominator_sets
  import ids_pkg::*;
#(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [NODE_W-1:0] cfg_wdata,
  ids_in_if.sink            in_ch,
  ids_out_if.source         out_ch
);
  localparam int unsigned AW = $clog2(MAX_NODES);

  typedef enum logic [3:0] {
    S_IDLE, S_EDGE_RD, S_EDGE_WR, S_CLEAR, S_INIT, S_NODE_RD, S_NODE_PR,
    S_SCAN, S_ACC, S_WB, S_EMIT_RD, S_EMIT, S_OUT
  } state_t;

  state_t             state_r;
  logic [NODE_W-1:0]  ncfg_r;
  logic [1:0]         mode_r;
  logic [NODE_W-1:0]  from_r, to_r;
  logic [AW-1:0]      idx_r;
  logic [ROW_W-1:0]   preds_r, acc_r, all_r;
  logic [AW:0]        n_r;
  logic               chg_r;
  logic               ov_r;
  logic               ov_nxt;
  logic [1:0]         ost_r;
  logic [NODE_W-1:0]  onode_r;
  logic [ROW_W-1:0]   odom_r;
  logic               olast_r;

  logic               p_we, d_we;
  logic [AW-1:0]      p_wa, p_ra, d_wa, d_ra;
  logic [ROW_W-1:0]   p_wd, p_rd, d_wd, d_rd;

  ids_mem #(.DEPTH(MAX_NODES), .WIDTH(ROW_W)) u_pred (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  ids_mem #(.DEPTH(MAX_NODES), .WIDTH(ROW_W)) u_dom (
    .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));

  logic [AW:0] n_use;
  always_comb begin
    if (ncfg_r == '0) n_use = (AW+1)'(1);
    else if ({1'b0, ncfg_r} > (NODE_W+1)'(MAX_NODES)) n_use = (AW+1)'(MAX_NODES);
    else n_use = (AW+1)'(ncfg_r);
  end

  logic out_free;
  assign out_free = !ov_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  logic edge_bad;
  always_comb begin
    if (mode_r == MODE_CLEAR) edge_bad = 1'b0;
    else edge_bad = (mode_r != MODE_ADD) || from_r == '0 || to_r == '0 ||
                    {1'b0, from_r} > (NODE_W+1)'(n_r) ||
                    {1'b0, to_r} > (NODE_W+1)'(n_r);
  end

  assign ov_nxt = (((state_r == S_EMIT) || (state_r == S_OUT)) && out_free) ? 1'b1 :
                  (ov_r && !out_ch.ready);

  logic [ROW_W-1:0] preds_m, rest_m;
  logic [AW-1:0]    low_p;
  logic             any_p;
  always_comb begin
    preds_m = preds_r;
    low_p = '0;
    any_p = 1'b0;
    for (int k = MAX_NODES - 1; k >= 0; k--) begin
      if (preds_m[k]) begin
        low_p = AW'(k);
        any_p = 1'b1;
      end
    end
    rest_m = preds_m & ~(ROW_W'(1) << low_p);
  end

  logic [ROW_W-1:0] nxt_row;
  assign nxt_row = acc_r | (ROW_W'(1) << idx_r);

  logic idx_last;
  assign idx_last = ({1'b0, idx_r} == n_r - (AW+1)'(1));

  always_comb begin
    p_we = 1'b0; p_wa = idx_r; p_wd = '0; p_ra = idx_r;
    d_we = 1'b0; d_wa = idx_r; d_wd = '0; d_ra = idx_r;
    case (state_r)
      S_IDLE:    p_ra = AW'(in_ch.to_node - NODE_W'(1));
      S_EDGE_RD: p_ra = AW'(to_r - NODE_W'(1));
      S_EDGE_WR: begin
        p_we = 1'b1;
        p_wa = AW'(to_r - NODE_W'(1));
        p_wd = p_rd | (ROW_W'(1) << AW'(from_r - NODE_W'(1)));
      end
      S_CLEAR:   p_we = 1'b1;
      S_INIT: begin
        d_we = 1'b1;
        d_wd = (idx_r == '0) ? ROW_W'(1) : all_r;
      end
      S_SCAN:    d_ra = any_p ? low_p : idx_r;
      S_WB: begin
        d_we = (nxt_row != d_rd);
        d_wd = nxt_row;
      end
      S_NODE_PR: d_ra = idx_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r   <= '0;
      mode_r  <= MODE_ADD;
      ncfg_r  <= NODE_W'(64);
      ov_r    <= 1'b0;
      chg_r   <= 1'b0;
    end else begin
      if (cfg_we) ncfg_r <= cfg_wdata;
      ov_r <= ov_nxt;
      case (state_r)
        S_IDLE: if (in_ch.valid) begin
          mode_r <= in_ch.mode;
          from_r <= in_ch.from_node;
          to_r   <= in_ch.to_node;
          n_r    <= n_use;
          idx_r  <= '0;
          all_r  <= (n_use == (AW+1)'(ROW_W)) ? '1 :
                    ((ROW_W'(1) << n_use) - ROW_W'(1));
          case (in_ch.mode)
            MODE_ADD:     state_r <= S_EDGE_RD;
            MODE_COMPUTE: state_r <= S_INIT;
            MODE_CLEAR:   state_r <= S_CLEAR;
            default:      state_r <= S_EDGE_RD;
          endcase
        end
        S_EDGE_RD: state_r <= edge_bad ? S_OUT : S_EDGE_WR;
        S_EDGE_WR: state_r <= S_OUT;
        S_CLEAR: begin
          idx_r <= idx_r + AW'(1);
          if (idx_r == AW'(MAX_NODES - 1))
            state_r <= (mode_r == MODE_CLEAR) ? S_OUT : S_IDLE;
        end
        S_INIT: begin
          chg_r <= 1'b0;
          if (idx_last) begin
            state_r <= (n_r == (AW+1)'(1)) ? S_EMIT_RD : S_NODE_RD;
            idx_r   <= (n_r == (AW+1)'(1)) ? '0 : AW'(1);
          end else idx_r <= idx_r + AW'(1);
        end
        S_NODE_RD: state_r <= S_NODE_PR;
        S_NODE_PR: begin
          preds_r <= p_rd & all_r;
          acc_r   <= (p_rd & all_r) == '0 ? '0 : all_r;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (any_p) begin
            preds_r <= rest_m;
            state_r <= S_ACC;
          end else state_r <= S_WB;
        end
        S_ACC: begin
          acc_r <= acc_r & d_rd;
          state_r <= S_SCAN;
        end
        S_WB: begin
          if (idx_last) begin
            if (chg_r || nxt_row != d_rd) begin
              chg_r <= 1'b0;
              idx_r <= AW'(1);
              state_r <= S_NODE_RD;
            end else begin
              idx_r <= '0;
              state_r <= S_EMIT_RD;
            end
          end else begin
            if (nxt_row != d_rd) chg_r <= 1'b1;
            idx_r <= idx_r + AW'(1);
            state_r <= S_NODE_RD;
          end
        end
        S_EMIT_RD: if (out_free) state_r <= S_EMIT;
        S_EMIT: if (out_free) begin
          ost_r   <= ST_ROW;
          onode_r <= NODE_W'(idx_r) + NODE_W'(1);
          odom_r  <= d_rd;
          olast_r <= idx_last;
          if (idx_last) state_r <= S_IDLE;
          else begin
            idx_r <= idx_r + AW'(1);
            state_r <= S_EMIT_RD;
          end
        end
        S_OUT: if (out_free) begin
          ost_r   <= edge_bad ? ST_BAD : ST_OK;
          onode_r <= '0;
          odom_r  <= '0;
          olast_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.status     = ost_r;
  assign out_ch.node       = onode_r;
  assign out_ch.dominators = odom_r;
  assign out_ch.last       = olast_r;

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_row_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ost_r == ST_ROW |-> odom_r != '0) else $error("empty dominator row");
  a_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ost_r != ST_ROW |-> odom_r == '0 && onode_r == '0 && olast_r)
    else $error("bad edge result");
endmodule

// ===== dv/tb_iterative_dominator_sets.sv =====
// ----------------------------------------------------------------------------
// tb_iterative_dominator_sets
// Self-checking bench for the dominator set engine. Edge, compute, clear and
// unused-mode words are driven with random gaps on both channels. A
// scoreboard keeps its own copy of the predecessor matrix and node count. It
// solves the dominator sets of every compute word itself, and checks each
// result word in order against what it predicted.
// ----------------------------------------------------------------------------
module tb_iterative_dominator_sets;
  import ids_pkg::*;

  localparam int unsigned NODES     = 64;
  localparam int unsigned LIMIT     = 3000000;
  localparam logic [1:0]  MODE_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]        status;
    logic [NODE_W-1:0] node;
    logic [ROW_W-1:0]  dominators;
    logic              last;
  } result_t;

  class dominator_scoreboard;
    logic [ROW_W-1:0]  pred_rows [NODES];
    logic [NODE_W-1:0] node_count;
    result_t           expected_q [$];
    int                errors;
    int                rows_seen;
    int                words_seen;

    function new();
      foreach (pred_rows[i]) pred_rows[i] = '0;
      node_count = 7'd64;
      errors     = 0;
      rows_seen  = 0;
      words_seen = 0;
    endfunction

    function int unsigned active_nodes();
      if (node_count < 1) return 1;
      if (node_count > NODES) return NODES;
      return node_count;
    endfunction

    function void push(logic [1:0] st, int unsigned nd, logic [ROW_W-1:0] d, logic l);
      result_t r;
      r.status     = st;
      r.node       = nd[NODE_W-1:0];
      r.dominators = d;
      r.last       = l;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void note_input(logic [1:0] mode, logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst);
      int unsigned      n;
      logic [ROW_W-1:0] all;
      logic [ROW_W-1:0] doms [NODES];
      logic [ROW_W-1:0] preds;
      logic [ROW_W-1:0] acc;
      logic [ROW_W-1:0] nxt;
      logic             changed;
      n   = active_nodes();
      all = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
      case (mode)
        MODE_ADD: begin
          if (src < 1 || src > n || dst < 1 || dst > n) begin
            push(ST_BAD, 0, '0, 1'b1);
          end else begin
            pred_rows[dst-1][src-1] = 1'b1;
            push(ST_OK, 0, '0, 1'b1);
          end
        end
        MODE_COMPUTE: begin
          doms[0] = 64'd1;
          for (int i = 1; i < NODES; i++) doms[i] = all;
          changed = 1'b1;
          while (changed) begin
            changed = 1'b0;
            for (int i = 1; i < n; i++) begin
              preds = pred_rows[i] & all;
              acc   = all;
              if (preds == '0) begin
                acc = '0;
              end else begin
                for (int p = 0; p < n; p++)
                  if (preds[p]) acc &= doms[p];
              end
              nxt    = acc;
              nxt[i] = 1'b1;
              if (nxt != doms[i]) begin
                doms[i] = nxt;
                changed = 1'b1;
              end
            end
          end
          for (int i = 0; i < n; i++) push(ST_ROW, i + 1, doms[i], (i + 1 == n));
        end
        MODE_CLEAR: begin
          foreach (pred_rows[i]) pred_rows[i] = '0;
          push(ST_OK, 0, '0, 1'b1);
        end
        default: push(ST_BAD, 0, '0, 1'b1);
      endcase
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check_result(result_t got);
      result_t exp;
      words_seen++;
      if (got.status == ST_ROW) rows_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected word status %0d node %0d", got.status, got.node));
      end else begin
        exp = expected_q.pop_front();
        if (got.status !== exp.status)
          report($sformatf("status %0d, want %0d", got.status, exp.status));
        if (got.node !== exp.node)
          report($sformatf("node %0d, want %0d", got.node, exp.node));
        if (got.dominators !== exp.dominators)
          report($sformatf("node %0d dominators %h, want %h", exp.node,
                           got.dominators, exp.dominators));
        if (got.last !== exp.last)
          report($sformatf("node %0d last %0d, want %0d", exp.node, got.last, exp.last));
      end
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [NODE_W-1:0] cfg_wdata;
  int unsigned       cycles;
  bit                quiet;
  int                in_words;

  ids_in_if  in_ch ();
  ids_out_if out_ch ();

  dominator_scoreboard sb;

  iterative_dominator_sets u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_iterative_dominator_sets NOT OK");
      $finish;
    end
  end

  // result side: sample at the rising edge
  always @(posedge clk) begin
    result_t r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      r.status     = out_ch.status;
      r.node       = out_ch.node;
      r.dominators = out_ch.dominators;
      r.last       = out_ch.last;
      sb.check_result(r);
    end
  end

  // result side stalls in bursts
  int unsigned stall_left;
  always @(negedge clk) begin
    if (quiet || !rst_n) begin
      out_ch.ready = 1'b1;
      stall_left   = 0;
    end else if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ch.ready = 1'b0;
      stall_left   = $urandom_range(0, 4);
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  task send_word(logic [1:0] mode, logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.mode      = mode;
    in_ch.from_node = src;
    in_ch.to_node   = dst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(mode, src, dst);
    in_words++;
  endtask

  task drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    // idle margin before the next phase; a clear has finished once its word arrived
    repeat (NODES + 40) @(posedge clk);
  endtask

  task write_count(logic [NODE_W-1:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.node_count = v;
  endtask

  task random_phase(int unsigned items);
    int unsigned n;
    int unsigned r;
    n = sb.active_nodes();
    if ($urandom_range(0, 2) == 0) send_word(MODE_CLEAR, 7'($urandom), 7'($urandom));
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 80)
        send_word(MODE_ADD, 7'($urandom_range(1, n)), 7'($urandom_range(1, n)));
      else if (r < 90)
        send_word(MODE_ADD, 7'($urandom), 7'($urandom));
      else if (r < 93)
        send_word(MODE_NONE, 7'($urandom), 7'($urandom));
      else if (r < 96)
        send_word(MODE_CLEAR, 7'($urandom), 7'($urandom));
      else
        send_word(MODE_COMPUTE, 7'($urandom), 7'($urandom));
    end
    send_word(MODE_COMPUTE, 7'($urandom), 7'($urandom));
  endtask

  initial begin
    int unsigned n;
    sb            = new();
    cycles        = 0;
    in_words      = 0;
    quiet         = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.mode    = MODE_ADD;
    in_ch.from_node = '0;
    in_ch.to_node = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // clear pass after reset
    repeat (NODES + 20) @(posedge clk);

    // directed, full count after reset
    send_word(MODE_ADD, 7'd1, 7'd2);
    send_word(MODE_ADD, 7'd1, 7'd2);
    send_word(MODE_ADD, 7'd2, 7'd3);
    send_word(MODE_ADD, 7'd3, 7'd2);
    send_word(MODE_ADD, 7'd2, 7'd1);
    send_word(MODE_ADD, 7'd64, 7'd64);
    send_word(MODE_ADD, 7'd10, 7'd5);
    send_word(MODE_ADD, 7'd0, 7'd5);
    send_word(MODE_ADD, 7'd5, 7'd0);
    send_word(MODE_ADD, 7'd65, 7'd1);
    send_word(MODE_ADD, 7'd127, 7'd127);
    send_word(MODE_NONE, 7'd127, 7'd127);
    send_word(MODE_COMPUTE, 7'd0, 7'd0);
    drain();
    write_count(7'd4);
    send_word(MODE_ADD, 7'd5, 7'd2);
    send_word(MODE_ADD, 7'd4, 7'd4);
    send_word(MODE_COMPUTE, 7'd127, 7'd127);
    send_word(MODE_CLEAR, 7'd0, 7'd0);
    send_word(MODE_COMPUTE, 7'd0, 7'd0);
    drain();
    write_count(7'd0);
    send_word(MODE_ADD, 7'd1, 7'd1);
    send_word(MODE_ADD, 7'd1, 7'd2);
    send_word(MODE_COMPUTE, 7'd0, 7'd0);
    drain();
    write_count(7'd127);
    send_word(MODE_COMPUTE, 7'd0, 7'd0);
    drain();
    write_count(7'd2);
    send_word(MODE_ADD, 7'd2, 7'd2);
    send_word(MODE_COMPUTE, 7'd0, 7'd0);
    drain();

    // random phases, last one with no gaps or stalls
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) quiet = 1'b1;
      case ($urandom_range(0, 9))
        0: n = 64;
        1: n = 1;
        default: n = $urandom_range(2, 12);
      endcase
      if (ph == 3) n = 64;
      write_count(7'(n));
      random_phase((n == 64) ? 24 : 12);
      drain();
    end

    $display("%0d command words, %0d result words, %0d dominator rows in %0d cycles",
             in_words, sb.words_seen, sb.rows_seen, cycles);
    $display("node counts from 0 to 127, bad edges, clears and unused mode covered");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_iterative_dominator_sets OK");
    end else begin
      $display("tb_iterative_dominator_sets NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ids_pkg.sv
rtl/core/ids_if.sv
rtl/core/ids_mem.sv
rtl/core/iterative_dominator_sets.sv
dv/tb_iterative_dominator_sets.sv
